// ----- rtl/cha_pkg.sv -----
// Shared types and constants for the ChaCha20 stream cipher block.
`timescale 1ns / 1ps
`default_nettype none

package cha_pkg;

  // Item and bus geometry
  localparam int BYTES_PER_ITEM = 8;
  localparam int DATA_W         = 64;
  localparam int CNT_W          = 4;
  localparam int TDATA_W        = 72;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_W          = 64;

  // Cipher geometry
  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_W     = 512;
  localparam int KEY_W       = 256;
  localparam int NONCE_W     = 96;
  localparam int CTR_W       = 32;
  localparam int ROUNDS      = 20;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_NONCE0 = 3'd4,
    CFG_NONCE1 = 3'd5,
    CFG_START  = 3'd6
  } cha_cfg_idx_t;

  // One request as it sits in the queue
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } cha_item_t;

  // Keystream core control and status
  typedef struct packed {
    logic start;
    logic abort;
  } cha_core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cha_core_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/cha_front.sv -----
// Input side: takes requests, clamps the byte count and hands them to the queue.
`timescale 1ns / 1ps
`default_nettype none

module cha_front import cha_pkg::*; (
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // [63:0] data_in, [67:64] byte_count, rest zero
  input  wire logic               in_tlast,
  input  wire logic               q_full,
  output logic                    q_push,
  output cha_item_t               q_item
);

  logic [CNT_W-1:0] raw_cnt;

  assign raw_cnt   = in_tdata[DATA_W +: CNT_W];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Clamp the count to the item width
  always_comb begin
    q_item.data = in_tdata[DATA_W-1:0];
    q_item.last = in_tlast;
    if (raw_cnt > CNT_W'(BYTES_PER_ITEM)) begin
      q_item.cnt = CNT_W'(BYTES_PER_ITEM);
    end else begin
      q_item.cnt = raw_cnt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cha_queue.sv -----
// Short request queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module cha_queue import cha_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  cha_item_t      push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output cha_item_t      head_item
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  cha_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0]  fill_r;
  logic               do_push, do_pop;

  assign full       = (fill_r == FILL_W'(DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cha_core.sv -----
// ChaCha20 block function: one round per cycle, final add on the way out.
`timescale 1ns / 1ps
`default_nettype none

module cha_core import cha_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [KEY_W-1:0]   key,
  input  wire logic [NONCE_W-1:0] nonce,
  input  wire logic [CTR_W-1:0]   ctr,
  input  cha_core_req_t           req,
  output cha_core_rsp_t           rsp,
  output logic [BLOCK_W-1:0]      blk
);

  localparam int RND_W = $clog2(ROUNDS + 1);

  logic [31:0]      st_r   [16];
  logic [31:0]      st_nxt [16];
  logic [31:0]      init_w [16];
  logic [RND_W-1:0] rnd_r;
  logic             busy_r;
  logic             last_rnd;

  function automatic logic [127:0] qr(input logic [31:0] a_i, input logic [31:0] b_i,
                                      input logic [31:0] c_i, input logic [31:0] d_i);
    logic [31:0] a, b, c, d;
    a = a_i;
    b = b_i;
    c = c_i;
    d = d_i;
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    return {d, c, b, a};
  endfunction

  // Build the starting state
  always_comb begin
    init_w[0] = SIGMA0;
    init_w[1] = SIGMA1;
    init_w[2] = SIGMA2;
    init_w[3] = SIGMA3;
    for (int j = 0; j < 8; j++) begin
      init_w[4 + j] = key[32*j +: 32];
    end
    init_w[12] = ctr;
    for (int j = 0; j < 3; j++) begin
      init_w[13 + j] = nonce[32*j +: 32];
    end
  end

  // One round: columns on even steps, diagonals on odd steps
  always_comb begin
    logic [3:0]   ia, ib, ic, id;
    logic [1:0]   sh;
    logic [127:0] q;
    st_nxt = st_r;
    sh     = rnd_r[0] ? 2'd1 : 2'd0;
    for (int i = 0; i < 4; i++) begin
      ia = {2'b00, 2'(i)};
      ib = {2'b01, 2'(2'(i) + sh)};
      ic = {2'b10, 2'(2'(i) + 2'(sh << 1))};
      id = {2'b11, 2'(2'(i) + 2'(sh * 2'd3))};
      q  = qr(st_r[ia], st_r[ib], st_r[ic], st_r[id]);
      st_nxt[ia] = q[31:0];
      st_nxt[ib] = q[63:32];
      st_nxt[ic] = q[95:64];
      st_nxt[id] = q[127:96];
    end
  end

  assign last_rnd = (rnd_r == RND_W'(ROUNDS));

  // Sequence the rounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
    end else if (req.abort) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      if (last_rnd) begin
        busy_r <= 1'b0;
      end else begin
        rnd_r <= rnd_r + 1'b1;
      end
    end else if (req.start) begin
      busy_r <= 1'b1;
      rnd_r  <= '0;
    end
  end

  // Working state
  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      st_r <= init_w;
    end else if (busy_r && !last_rnd) begin
      st_r <= st_nxt;
    end
  end

  // Feed-forward add produces the keystream block
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      blk[32*j +: 32] = st_r[j] + init_w[j];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = busy_r && last_rnd;

endmodule

`default_nettype wire

// ----- rtl/cha_back.sv -----
// Back end: keystream buffering, block prefetch, XOR and output register.
`timescale 1ns / 1ps
`default_nettype none

module cha_back import cha_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  cha_item_t               head_item,
  output logic                    pop,
  input  wire logic [CTR_W-1:0]   start_counter,
  output logic [CTR_W-1:0]        ctr,
  output cha_core_req_t           core_req,
  input  cha_core_rsp_t           core_rsp,
  input  wire logic [BLOCK_W-1:0] core_blk,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // [63:0] data_out, [67:64] byte_count_out, rest zero
  output logic                    out_tlast
);

  localparam int POS_W = $clog2(BLOCK_BYTES + 1);
  localparam int SP_W  = $clog2(BLOCK_BYTES);
  localparam int OFF_W = $clog2(BYTES_PER_ITEM + 1) - 1;

  // Control
  logic               act_r;
  logic [POS_W-1:0]   pos_r;
  logic               nxt_valid_r;
  logic [CTR_W-1:0]   ctr_r;
  logic               mid_r;
  logic               out_valid_r;
  // Payload
  logic [BLOCK_W-1:0] cur_blk_r, nxt_blk_r;
  logic [CNT_W-1:0]   rem_r;
  logic [OFF_W-1:0]   off_r;
  logic [DATA_W-1:0]  ksacc_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_last_r;

  logic               need_blk, activate, out_ok, go, fin, emit, take_nxt, done_ok, end_msg;
  logic [BLOCK_W-1:0] src, shifted;
  logic [SP_W-1:0]    spos;
  logic [POS_W-1:0]   avail;
  logic [CNT_W-1:0]   rem, n;
  logic [OFF_W-1:0]   off;
  logic [DATA_W-1:0]  ksacc, ks64, part, new_ks;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
    logic [DATA_W-1:0] m;
    for (int k = 0; k < BYTES_PER_ITEM; k++) begin
      m[8*k +: 8] = (CNT_W'(k) < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  // Pick the keystream source: the prefetched block once the current one is used up
  assign need_blk = (pos_r == POS_W'(BLOCK_BYTES));
  assign src      = need_blk ? nxt_blk_r : cur_blk_r;
  assign spos     = need_blk ? '0 : pos_r[SP_W-1:0];
  assign avail    = POS_W'(BLOCK_BYTES) - {1'b0, spos};

  // Resume a request that straddles a block boundary
  assign rem   = mid_r ? rem_r : head_item.cnt;
  assign off   = mid_r ? off_r : '0;
  assign ksacc = mid_r ? ksacc_r : '0;
  assign n     = ({{(POS_W-CNT_W){1'b0}}, rem} < avail) ? rem : avail[CNT_W-1:0];

  // Align keystream bytes to their place in the request
  assign shifted = src >> {spos, 3'b000};
  assign ks64    = shifted[DATA_W-1:0];
  assign part    = (ks64 & byte_mask(n)) << {off, 3'b000};
  assign new_ks  = ksacc | part;

  assign activate = head_valid && !act_r;
  assign out_ok   = !out_valid_r || out_tready;
  assign go       = head_valid && act_r && out_ok && ((rem == '0) || !need_blk || nxt_valid_r);
  assign fin      = (n == rem);
  assign emit     = go && fin;
  assign take_nxt = go && need_blk && (rem != '0);
  assign end_msg  = emit && head_item.last;
  assign done_ok  = core_rsp.done && !end_msg;
  assign pop      = emit;

  // Prefetch the next block whenever a message is active, the spare buffer is empty and the core is idle
  assign core_req.start = act_r && !nxt_valid_r && !core_rsp.busy;
  assign core_req.abort = end_msg;

  // Message, cursor and counter control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      pos_r       <= POS_W'(BLOCK_BYTES);
      nxt_valid_r <= 1'b0;
      ctr_r       <= '0;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (activate) begin
        act_r       <= 1'b1;
        pos_r       <= POS_W'(BLOCK_BYTES);
        nxt_valid_r <= 1'b0;
        ctr_r       <= start_counter;
      end else if (end_msg) begin
        act_r       <= 1'b0;
        pos_r       <= POS_W'(BLOCK_BYTES);
        nxt_valid_r <= 1'b0;
      end else begin
        if (go && (rem != '0)) begin
          pos_r <= {1'b0, spos} + {{(POS_W-CNT_W){1'b0}}, n};
        end
        if (take_nxt) begin
          nxt_valid_r <= 1'b0;
        end else if (done_ok) begin
          nxt_valid_r <= 1'b1;
          ctr_r       <= ctr_r + 1'b1;
        end
      end
      if (go && !fin) begin
        mid_r <= 1'b1;
      end else if (emit) begin
        mid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Keystream buffers and partial request state
  always_ff @(posedge clk) begin
    if (take_nxt) begin
      cur_blk_r <= nxt_blk_r;
    end
    if (done_ok) begin
      nxt_blk_r <= core_blk;
    end
    if (go && !fin) begin
      rem_r   <= rem - n;
      off_r   <= off + OFF_W'(n);
      ksacc_r <= new_ks;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= (head_item.data ^ new_ks) & byte_mask(head_item.cnt);
      out_cnt_r  <= head_item.cnt;
      out_last_r <= head_item.last;
    end
  end

  assign ctr        = ctr_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-DATA_W-CNT_W){1'b0}}, out_cnt_r, out_data_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/chacha20_stream_cipher_top.sv -----
// Top level of the ChaCha20 stream cipher: configuration registers and unit wiring.
`timescale 1ns / 1ps
`default_nettype none

// ChaCha20 (20 rounds) stream cipher. Each request carries up to eight message
// bytes and yields one response with the bytes XORed against one continuous
// keystream; the first request of a message loads the block counter from the
// start register, and a request with tlast ends the message. Requests enter a
// short queue and are served at one per cycle while keystream is buffered and
// the output is not stalled; a request that straddles a block boundary is
// finished from the next block. A 64-byte keystream block is computed in the
// round core (one ChaCha round per cycle, then the feed-forward add as the
// block is captured) and is prefetched into a spare buffer while the current
// block is consumed, so full-width requests are limited by keystream
// generation. The first response of a message waits for its first keystream
// block. The user must write the configuration only while no message is in
// flight; the block itself does not enforce this.
module chacha20_stream_cipher_top import cha_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [TDATA_W-1:0]   in_tdata,   // [63:0] data_in, [67:64] byte_count, rest zero
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [TDATA_W-1:0]        out_tdata,  // [63:0] data_out, [67:64] byte_count_out, rest zero
  output logic                      out_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [KEY_W-1:0]   key_r;
  logic [NONCE_W-1:0] nonce_r;
  logic [CTR_W-1:0]   start_r;

  logic               q_full, q_push, q_pop, head_valid;
  cha_item_t          q_item, head_item;
  logic [CTR_W-1:0]   ctr;
  cha_core_req_t      core_req;
  cha_core_rsp_t      core_rsp;
  logic [BLOCK_W-1:0] core_blk;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
      start_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY0:   key_r[63:0]      <= cfg_wdata;
        CFG_KEY1:   key_r[127:64]    <= cfg_wdata;
        CFG_KEY2:   key_r[191:128]   <= cfg_wdata;
        CFG_KEY3:   key_r[255:192]   <= cfg_wdata;
        CFG_NONCE0: nonce_r[63:0]    <= cfg_wdata;
        CFG_NONCE1: nonce_r[95:64]   <= cfg_wdata[31:0];
        CFG_START:  start_r          <= cfg_wdata[31:0];
        default:    ;
      endcase
    end
  end

  cha_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  cha_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  cha_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (key_r),
    .nonce (nonce_r),
    .ctr   (ctr),
    .req   (core_req),
    .rsp   (core_rsp),
    .blk   (core_blk)
  );

  cha_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (q_pop),
    .start_counter (start_r),
    .ctr           (ctr),
    .core_req      (core_req),
    .core_rsp      (core_rsp),
    .core_blk      (core_blk),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/cha_checker.sv -----
// Port-level checks on the cipher top level, bound to every instance.
`timescale 1ns / 1ps
`default_nettype none

module cha_checker import cha_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [TDATA_W-1:0]   out_tdata,
  input wire logic                 out_tlast
);

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("response valid right after reset");

  // A stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled response changed");

  // Reported byte count never exceeds the item width
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DATA_W +: CNT_W] <= CNT_W'(BYTES_PER_ITEM))
    else $error("response byte count out of range");

  // Bytes past the count are zero
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DATA_W-1:0] >> ({3'b000, out_tdata[DATA_W +: CNT_W]} * 7'd8)) == '0)
    else $error("response bytes beyond count not zero");

  // Response padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TDATA_W-1:DATA_W+CNT_W] == '0)
    else $error("response padding not zero");

endmodule

bind chacha20_stream_cipher_top cha_checker u_cha_checker (.*);

`default_nettype wire

// ----- bench/chacha20_stream_cipher_top_tb.sv -----
// Self-checking testbench for the ChaCha20 stream cipher top level.
`timescale 1ns / 1ps

module chacha20_stream_cipher_top_tb;
  import cha_pkg::*;

  localparam int SETTLE_CYCLES = 64;      // first keystream plus one prefetched block
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DOUBLE_ROUNDS = ROUNDS / 2;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;   // [63:0] data_in, [67:64] byte_count, rest zero
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;         // [63:0] data_out, [67:64] byte_count_out, rest zero
  logic                 out_tlast;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  // Mirror of the cipher configuration and keystream state
  logic [63:0]  key_word [4];
  logic [63:0]  nonce_lo;
  logic [31:0]  nonce_hi;
  logic [31:0]  start_ctr;
  logic [511:0] ks_block;
  logic [31:0]  blk_ctr;
  logic [5:0]   ks_cursor;
  logic         msg_open;

  cha_item_t pending_ciphertext [$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  chacha20_stream_cipher_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter_mix(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c, input logic [31:0] d);
    a = a + b; d = rotl32(d ^ a, 16);
    c = c + d; b = rotl32(b ^ c, 12);
    a = a + b; d = rotl32(d ^ a, 8);
    c = c + d; b = rotl32(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  // Compute one 64-byte keystream block; byte k lands at bits 8k+7:8k
  function automatic logic [511:0] keystream_block(input logic [31:0] ctr);
    logic [31:0]  init [16];
    logic [31:0]  w [16];
    logic [511:0] blk;
    int           i;
    int           r;
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_word[i][31:0];
      init[5 + 2 * i] = key_word[i][63:32];
    end
    init[12] = ctr;
    init[13] = nonce_lo[31:0];
    init[14] = nonce_lo[63:32];
    init[15] = nonce_hi;
    for (i = 0; i < 16; i++) w[i] = init[i];
    for (r = 0; r < DOUBLE_ROUNDS; r++) begin
      {w[0], w[4], w[8],  w[12]} = quarter_mix(w[0], w[4], w[8],  w[12]);
      {w[1], w[5], w[9],  w[13]} = quarter_mix(w[1], w[5], w[9],  w[13]);
      {w[2], w[6], w[10], w[14]} = quarter_mix(w[2], w[6], w[10], w[14]);
      {w[3], w[7], w[11], w[15]} = quarter_mix(w[3], w[7], w[11], w[15]);
      {w[0], w[5], w[10], w[15]} = quarter_mix(w[0], w[5], w[10], w[15]);
      {w[1], w[6], w[11], w[12]} = quarter_mix(w[1], w[6], w[11], w[12]);
      {w[2], w[7], w[8],  w[13]} = quarter_mix(w[2], w[7], w[8],  w[13]);
      {w[3], w[4], w[9],  w[14]} = quarter_mix(w[3], w[4], w[9],  w[14]);
    end
    for (i = 0; i < 16; i++) blk[32 * i +: 32] = w[i] + init[i];
    return blk;
  endfunction

  // Advance the keystream over one request and return the expected response
  function automatic cha_item_t encrypt_request(input cha_item_t req);
    cha_item_t   rsp;
    int          n;
    int          i;
    logic [63:0] ct;
    n  = (req.cnt > BYTES_PER_ITEM) ? BYTES_PER_ITEM : int'(req.cnt);
    ct = '0;
    if (!msg_open) begin
      blk_ctr   = start_ctr;
      ks_cursor = '0;
      msg_open  = 1'b1;
    end
    for (i = 0; i < n; i++) begin
      if (ks_cursor == 6'd0) begin
        ks_block = keystream_block(blk_ctr);
        blk_ctr  = blk_ctr + 32'd1;   // wraps silently
      end
      ct[8 * i +: 8] = req.data[8 * i +: 8] ^ ks_block[8 * ks_cursor +: 8];
      ks_cursor      = ks_cursor + 6'd1;
    end
    if (req.last) begin
      msg_open  = 1'b0;
      ks_cursor = '0;
    end
    rsp.data = ct;
    rsp.cnt  = n[CNT_W-1:0];
    rsp.last = req.last;
    return rsp;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got_v, want_v);
    mismatch_count++;
  endtask

  task automatic check_response();
    cha_item_t got;
    cha_item_t want;
    got.data = out_tdata[DATA_W-1:0];
    got.cnt  = out_tdata[DATA_W +: CNT_W];
    got.last = out_tlast;
    if (pending_ciphertext.size() == 0) begin
      report_mismatch("response with no request pending", got.data, '0);
    end else begin
      want = pending_ciphertext.pop_front();
      if (got.data !== want.data) report_mismatch("data_out", got.data, want.data);
      if (got.cnt !== want.cnt)
        report_mismatch("byte_count_out", 64'(got.cnt), 64'(want.cnt));
      if (got.last !== want.last)
        report_mismatch("last_out", 64'(got.last), 64'(want.last));
    end
  endtask

  // Take responses and stall the output at random
  always @(posedge clk) begin
    if (out_tvalid && out_tready) check_response();
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** chacha20_stream_cipher_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input cha_cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_KEY0:   key_word[0] = value;
      CFG_KEY1:   key_word[1] = value;
      CFG_KEY2:   key_word[2] = value;
      CFG_KEY3:   key_word[3] = value;
      CFG_NONCE0: nonce_lo    = value;
      CFG_NONCE1: nonce_hi    = value[31:0];
      CFG_START:  start_ctr   = value[31:0];
      default: ;
    endcase
  endtask

  // Program every register; upper bits of the narrow ones carry noise
  task automatic load_config(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] nlo, input logic [31:0] nhi,
                             input logic [31:0] ctr);
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_NONCE0, nlo);
    write_reg(CFG_NONCE1, {$urandom, nhi});
    write_reg(CFG_START, {$urandom, ctr});
    cfg_we <= 1'b0;
  endtask

  // Send one request; valid stays high after the handshake
  task automatic send_request(input logic [63:0] data, input logic [3:0] cnt,
                              input logic last);
    cha_item_t req;
    req.data = data;
    req.cnt  = cnt;
    req.last = last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_W - DATA_W - CNT_W){1'b0}}, cnt, data};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    pending_ciphertext.push_back(encrypt_request(req));
  endtask

  // Hold the input until every response is back, then let the core settle
  task automatic wait_idle(input int settle_cycles);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ciphertext.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
  endtask

  // Edge counts, saturation, short items and garbage above the count
  task automatic test_directed_edges();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
                64'h1f1e1d1c1b1a1918, 64'h4a00000000000000, 32'h0, 32'h1);
    send_request(64'h0, 4'd8, 1'b0);
    send_request('1, 4'd8, 1'b0);
    send_request(rand64(), 4'd0, 1'b0);
    send_request(rand64(), 4'd3, 1'b0);
    send_request(rand64(), 4'd15, 1'b0);
    send_request(rand64(), 4'd9, 1'b0);
    repeat (4) send_request(rand64(), 4'd8, 1'b0);
    send_request(rand64(), 4'd5, 1'b1);
    send_request(rand64(), 4'd8, 1'b1);
    send_request(rand64(), 4'd0, 1'b1);
    send_request(rand64(), 4'd1, 1'b1);
    wait_idle(SETTLE_CYCLES);
  endtask

  // Block counter rolls from all ones to zero within a message
  task automatic test_counter_wrap();
    load_config('1, '1, '1, '1, '1, '1, 32'hffff_ffff);
    repeat (8) send_request(rand64(), 4'd8, 1'b0);
    send_request(rand64(), 4'd8, 1'b1);
    send_request(rand64(), 4'd8, 1'b1);
    wait_idle(SETTLE_CYCLES);
  endtask

  // Random messages under one idling profile, with a fresh configuration
  task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
    int          sent;
    int          pause_at;
    int          len;
    int          k;
    bit          broken;
    logic        last_flag;
    logic [3:0]  cnt;
    logic [31:0] ctr;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    case ($urandom_range(3))
      0:       ctr = 32'h0;
      1:       ctr = 32'hffff_ffff - $urandom_range(3);
      default: ctr = $urandom;
    endcase
    if ($urandom_range(4) == 0)
      load_config('0, '0, '0, '0, '0, 32'h0, ctr);
    else
      load_config(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, ctr);
    sent     = 0;
    pause_at = $urandom_range(items / 4, 3 * items / 4);
    while (sent < items) begin
      len    = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      broken = ($urandom_range(4) == 0);
      for (k = 0; k < len; k++) begin
        last_flag = (k == len - 1);
        if (broken)
          cnt = 4'($urandom_range(15));
        else
          cnt = last_flag ? 4'($urandom_range(1, BYTES_PER_ITEM)) : 4'(BYTES_PER_ITEM);
        send_request(rand64(), cnt, last_flag);
        sent++;
        // drain mid-message once so the core restarts from an empty pipe
        if (sent == pause_at) wait_idle(0);
      end
    end
    wait_idle(SETTLE_CYCLES);
  endtask

  initial begin
    msg_open  = 1'b0;
    ks_cursor = '0;
    blk_ctr   = '0;
    ks_block  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_counter_wrap();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 66, 0);
    test_random_traffic(150, 0, 66);
    test_random_traffic(150, 27, 27);
    if (mismatch_count == 0) begin
      $display("** chacha20_stream_cipher_top: PASSED **");
    end else begin
      $display("** chacha20_stream_cipher_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cha_pkg.sv
rtl/cha_front.sv
rtl/cha_queue.sv
rtl/cha_core.sv
rtl/cha_back.sv
rtl/chacha20_stream_cipher_top.sv
rtl/cha_checker.sv
bench/chacha20_stream_cipher_top_tb.sv
